// ===== sv/tet_pkg.sv =====
// ============================================================================
// tet_pkg
// Shared types and constants for the token expiry table: request and
// response transactions, table entry layout and memory port bundle.
// ============================================================================
package tet_pkg;

    // Table geometry
    localparam int ENTRIES  = 16;
    localparam int KEY_BITS = 32;
    localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W    = $clog2(ENTRIES + 1);

    // Field widths of the transactions
    localparam int MODE_W   = 2;
    localparam int TKEY_W   = 32;
    localparam int TIME_W   = 32;
    localparam int EXP_W    = TIME_W + 1;
    localparam int LIVE_W   = 5;
    localparam int STAT_W   = 2;

    // Request modes
    localparam logic [MODE_W-1:0] MODE_GEN   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RENEW = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COUNT = 2'd2;

    // Response status codes
    localparam logic [STAT_W-1:0] ST_DONE       = 2'd0;
    localparam logic [STAT_W-1:0] ST_RENEW_MISS = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL       = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [TKEY_W-1:0] token_key;
        logic [TIME_W-1:0] now;
    } t_req;

    typedef struct packed {
        logic [LIVE_W-1:0] live_count;
        logic [STAT_W-1:0] status;
    } t_rsp;

    // One stored table entry
    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [EXP_W-1:0]    expiry;
    } t_entry;

    // Control bundle from the sequencer to the entry memory
    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        t_entry           wr_data;
    } t_mem_req;

endpackage

// ===== sv/tet_mem.sv =====
// ============================================================================
// tet_mem
// Entry store for key and expiry: one write port, one read port with
// registered read data.
// ============================================================================
module tet_mem (
    input  logic              i_clk,
    input  tet_pkg::t_mem_req i_mem,
    output tet_pkg::t_entry   o_rd_data
);
    import tet_pkg::*;

    t_entry r_mem [ENTRIES];
    t_entry r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_mem.wr_en) begin
            r_mem[i_mem.wr_addr] <= i_mem.wr_data;
        end
    end

    // Read port
    always_ff @(posedge i_clk) begin
        if (i_mem.rd_en) begin
            r_rd_data <= r_mem[i_mem.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/tet_ctrl.sv =====
// ============================================================================
// tet_ctrl
// Request sequencer: sweeps the entry memory once per request, retiring
// expired entries and locating the key and the lowest free slot, then
// writes the updated entry back and presents the response.
// ============================================================================
module tet_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_req_valid,
    input  tet_pkg::t_req                i_req,
    output logic                         o_req_ready,
    input  logic [tet_pkg::TIME_W-1:0]   i_lifetime,
    output tet_pkg::t_mem_req            o_mem,
    input  tet_pkg::t_entry              i_rd_data,
    output logic                         o_rsp_valid,
    output tet_pkg::t_rsp                o_rsp,
    input  logic                         i_rsp_free
);
    import tet_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_DONE
    } t_state;

    t_state              r_state;
    t_req                r_req;
    logic [ENTRIES-1:0]  r_valid;
    logic [CNT_W-1:0]    r_live;
    logic [CNT_W-1:0]    r_issue;
    logic                r_chk_vld;
    logic [IDX_W-1:0]    r_chk_idx;
    logic                r_hit;
    logic [IDX_W-1:0]    r_hit_idx;
    logic                r_free;
    logic [IDX_W-1:0]    r_free_idx;
    logic [STAT_W-1:0]   r_status;

    logic                issue;
    logic                chk_valid;
    logic                retire;
    logic                key_match;
    logic [KEY_BITS-1:0] req_key;
    logic [EXP_W-1:0]    new_expiry;
    logic                do_update;
    logic                do_insert;
    logic                is_gen;
    logic                is_renew;

    // Sweep address issue and checks on returning read data
    assign req_key    = r_req.token_key[KEY_BITS-1:0];
    assign issue      = (r_state == S_SCAN) && (r_issue < CNT_W'(ENTRIES));
    assign chk_valid  = r_chk_vld && r_valid[r_chk_idx];
    assign retire     = chk_valid && (i_rd_data.expiry <= {1'b0, r_req.now});
    assign key_match  = chk_valid && !retire && (i_rd_data.key == req_key);

    // Write-back decision
    assign new_expiry = {1'b0, r_req.now} + {1'b0, i_lifetime};
    assign is_gen     = (r_req.mode == MODE_GEN);
    assign is_renew   = (r_req.mode == MODE_RENEW);
    assign do_update  = (r_state == S_WRITE) && (is_gen || is_renew) && r_hit;
    assign do_insert  = (r_state == S_WRITE) && is_gen && !r_hit && r_free;

    // Memory port
    always_comb begin
        o_mem.rd_en          = issue;
        o_mem.rd_addr        = r_issue[IDX_W-1:0];
        o_mem.wr_en          = do_update || do_insert;
        o_mem.wr_addr        = r_hit ? r_hit_idx : r_free_idx;
        o_mem.wr_data.key    = req_key;
        o_mem.wr_data.expiry = new_expiry;
    end

    // Sequencer, valid bits and live counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_live    <= '0;
            r_chk_vld <= 1'b0;
            r_issue   <= '0;
            r_hit     <= 1'b0;
            r_free    <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_req     <= i_req;
                        r_issue   <= '0;
                        r_chk_vld <= 1'b0;
                        r_hit     <= 1'b0;
                        r_free    <= 1'b0;
                        r_state   <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_chk_vld <= issue;
                    r_chk_idx <= r_issue[IDX_W-1:0];
                    if (issue) begin
                        r_issue <= r_issue + CNT_W'(1);
                    end
                    if (r_chk_vld) begin
                        if (retire) begin
                            r_valid[r_chk_idx] <= 1'b0;
                            r_live             <= r_live - CNT_W'(1);
                        end
                        if (key_match && !r_hit) begin
                            r_hit     <= 1'b1;
                            r_hit_idx <= r_chk_idx;
                        end
                        // free after ageing: empty or just retired
                        if ((!chk_valid || retire) && !r_free) begin
                            r_free     <= 1'b1;
                            r_free_idx <= r_chk_idx;
                        end
                        if (r_chk_idx == IDX_W'(ENTRIES - 1)) begin
                            r_state <= S_WRITE;
                        end
                    end
                end
                S_WRITE: begin
                    if (do_insert) begin
                        r_valid[r_free_idx] <= 1'b1;
                        r_live              <= r_live + CNT_W'(1);
                    end
                    if (is_gen && !r_hit && !r_free) begin
                        r_status <= ST_FULL;
                    end else if (is_renew && !r_hit) begin
                        r_status <= ST_RENEW_MISS;
                    end else begin
                        r_status <= ST_DONE;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (i_rsp_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_req_ready     = (r_state == S_IDLE);
    assign o_rsp_valid     = (r_state == S_DONE);
    assign o_rsp.live_count = LIVE_W'(r_live);
    assign o_rsp.status     = r_status;

endmodule

// ===== sv/token_expiry_table.sv =====
// ============================================================================
// token_expiry_table
// Ageing table of token keys with expiry times: generate, renew and count
// requests, each answered by one response with the live count and a status.
// ============================================================================
//
//  channel   direction  handshake                    payload
//  request   in         i_req_valid / o_req_stall    i_req  (t_req)
//  response  out        o_rsp_valid / i_rsp_stall    o_rsp  (t_rsp)
//  config    in         i_cfg_valid / o_cfg_ready    i_cfg_lifetime
//
//  A request is accepted, then swept over the entry memory (one read per
//  cycle, with registered read data), written back, and its response
//  handed to the output register.
//  Reset is synchronous, active low; it empties the table and sets the
//  lifetime to 1. No memory clearing pass is needed: entry valid bits live
//  in flip-flops. A response waiting in the output register does not block the
//  next request; the sequencer only holds when that register is full and stalled.
//
module token_expiry_table (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_req_valid,
    output logic                       o_req_stall,
    input  tet_pkg::t_req              i_req,
    output logic                       o_rsp_valid,
    input  logic                       i_rsp_stall,
    output tet_pkg::t_rsp              o_rsp,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [tet_pkg::TIME_W-1:0] i_cfg_lifetime
);
    import tet_pkg::*;

    logic [TIME_W-1:0] r_lifetime;
    logic              r_out_valid;
    t_rsp              r_out;

    logic              req_ready;
    t_mem_req          mem_req;
    t_entry            rd_data;
    logic              rsp_valid;
    t_rsp              rsp;
    logic              rsp_free;

    // Lifetime register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lifetime <= TIME_W'(1);
        end else if (i_cfg_valid) begin
            r_lifetime <= i_cfg_lifetime;
        end
    end

    tet_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .i_req       (i_req),
        .o_req_ready (req_ready),
        .i_lifetime  (r_lifetime),
        .o_mem       (mem_req),
        .i_rd_data   (rd_data),
        .o_rsp_valid (rsp_valid),
        .o_rsp       (rsp),
        .i_rsp_free  (rsp_free)
    );

    tet_mem u_mem (
        .i_clk     (i_clk),
        .i_mem     (mem_req),
        .o_rd_data (rd_data)
    );

    // Output register
    assign rsp_free = !r_out_valid || !i_rsp_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (rsp_valid && rsp_free) begin
            r_out_valid <= 1'b1;
            r_out       <= rsp;
        end else if (!i_rsp_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_req_stall = !req_ready;
    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for the token expiry table. A scoreboard class keeps
// its own copy of the table and the lifetime, predicts the reply to every
// accepted request and checks each reply field by field, oldest first.
// Stimulus opens with a short directed run and then random phases under
// several lifetimes, with random idling on both channels.
// ============================================================================
module tb;
    import tet_pkg::*;

    // Mode value the block leaves unused; it must behave as a count
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int KEY_POOL    = 24;

    // ------------------------------------------------------------------------
    // Scoreboard: shadow table, reply prediction and checking
    // ------------------------------------------------------------------------
    class expiry_scoreboard;
        logic                used   [ENTRIES];
        logic [KEY_BITS-1:0] keys   [ENTRIES];
        logic [EXP_W-1:0]    expiry [ENTRIES];
        logic [TIME_W-1:0]   lifetime;
        int                  live;
        t_rsp                replies [$];
        int                  errors;

        function new();
            foreach (used[i]) used[i] = 1'b0;
            lifetime = 1;
            live     = 0;
            errors   = 0;
        endfunction

        function void set_lifetime(logic [TIME_W-1:0] value);
            lifetime = value;
        endfunction

        function int pending();
            return replies.size();
        endfunction

        // Work out the reply to one accepted request and update the shadow table
        function void note_request(t_req r);
            logic [EXP_W-1:0] deadline;
            int               slot;
            t_rsp             want;
            deadline = {1'b0, r.now} + {1'b0, lifetime};
            // retire everything due at or before the request time
            for (int i = 0; i < ENTRIES; i++) begin
                if (used[i] && expiry[i] <= {1'b0, r.now}) begin
                    used[i] = 1'b0;
                    live--;
                end
            end
            want.status = ST_DONE;
            slot = -1;
            if (r.mode == MODE_GEN || r.mode == MODE_RENEW) begin
                for (int i = 0; i < ENTRIES; i++)
                    if (slot < 0 && used[i] && keys[i] == r.token_key[KEY_BITS-1:0])
                        slot = i;
                if (slot >= 0) begin
                    expiry[slot] = deadline;
                end else if (r.mode == MODE_RENEW) begin
                    want.status = ST_RENEW_MISS;
                end else begin
                    // lowest free slot takes the new key
                    for (int i = 0; i < ENTRIES; i++)
                        if (slot < 0 && !used[i]) slot = i;
                    if (slot < 0) begin
                        want.status = ST_FULL;
                    end else begin
                        used[slot]   = 1'b1;
                        keys[slot]   = r.token_key[KEY_BITS-1:0];
                        expiry[slot] = deadline;
                        live++;
                    end
                end
            end
            want.live_count = LIVE_W'(live);
            replies.insert(replies.size(), want);
        endfunction

        task report_mismatch(string what, int got, int want);
            errors++;
            $display("%0t ns: %s: got %0d, want %0d", $time, what, got, want);
        endtask

        // Compare one reply transaction against the oldest prediction
        task check_reply(t_rsp got);
            t_rsp want;
            if (replies.size() == 0) begin
                report_mismatch("reply with no request outstanding", got.status, -1);
            end else begin
                want = replies[0];
                replies.delete(0);
                if (got.live_count !== want.live_count)
                    report_mismatch("live_count", got.live_count, want.live_count);
                if (got.status !== want.status)
                    report_mismatch("status", got.status, want.status);
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------------
    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              req_valid    = 1'b0;
    logic              req_stall;
    t_req              req          = '0;
    logic              rsp_valid;
    logic              rsp_stall    = 1'b0;
    t_rsp              rsp;
    logic              cfg_valid    = 1'b0;
    logic              cfg_ready;
    logic [TIME_W-1:0] cfg_lifetime = '0;

    expiry_scoreboard  board;
    bit                tx_idle      = 1'b1;
    bit                rx_idle      = 1'b1;
    int                stall_left   = 0;
    int                cycles       = 0;
    longint            base_now     = 0;

    always #6 clk = ~clk;

    token_expiry_table i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_req_valid    (req_valid),
        .o_req_stall    (req_stall),
        .i_req          (req),
        .o_rsp_valid    (rsp_valid),
        .i_rsp_stall    (rsp_stall),
        .o_rsp          (rsp),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_lifetime (cfg_lifetime)
    );

    // Reply side: random stall bursts
    always @(negedge clk) begin
        if (stall_left != 0) begin
            rsp_stall  <= 1'b1;
            stall_left = stall_left - 1;
        end else if (rx_idle && $urandom_range(0, 5) == 0) begin
            rsp_stall  <= 1'b1;
            stall_left = $urandom_range(0, 8);
        end else begin
            rsp_stall <= 1'b0;
        end
    end

    // Reply monitor
    always @(posedge clk) begin
        if (rst_n && rsp_valid && !rsp_stall)
            board.check_reply(rsp);
    end

    // Watchdog
    always @(posedge clk) cycles <= cycles + 1;

    initial begin
        while (cycles < CYCLE_LIMIT) @(posedge clk);
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Driving tasks
    // ------------------------------------------------------------------------

    // One request transaction, with an occasional gap before it
    task automatic send_req(input logic [MODE_W-1:0] mode, input logic [TKEY_W-1:0] key,
                            input logic [TIME_W-1:0] at);
        t_req r;
        r.mode      = mode;
        r.token_key = key;
        r.now       = at;
        if (tx_idle && $urandom_range(0, 3) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        board.note_request(r);
        @(negedge clk);
    endtask

    // Hold the request side until every outstanding reply is back
    task automatic drain_replies();
        req_valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_lifetime(input logic [TIME_W-1:0] value);
        drain_replies();
        cfg_valid    <= 1'b1;
        cfg_lifetime <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        board.set_lifetime(value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Random phase: keys mostly from a small pool so hits, refreshes and a
    // full table all occur; time mostly climbs, now and then steps back
    task automatic run_phase(input logic [TIME_W-1:0] life, input int max_step,
                             input int items, input bit quiet);
        logic [TKEY_W-1:0] pool [KEY_POOL];
        logic [TKEY_W-1:0] key;
        logic [MODE_W-1:0] mode;
        logic [TIME_W-1:0] at;
        longint            lower;
        int                pick;
        write_lifetime(life);
        foreach (pool[i]) pool[i] = $urandom;
        pool[0] = '0;
        pool[1] = '1;
        for (int n = 0; n < items; n++) begin
            if (n % 64 == 0) begin
                tx_idle = !quiet && $urandom_range(0, 3) != 0;
                rx_idle = !quiet && $urandom_range(0, 3) != 0;
            end
            if (n == items / 2)
                drain_replies();
            pick = $urandom_range(0, 99);
            mode = (pick < 45) ? MODE_GEN : (pick < 75) ? MODE_RENEW :
                   (pick < 95) ? MODE_COUNT : MODE_SPARE;
            key = ($urandom_range(0, 6) == 0) ? TKEY_W'($urandom)
                                               : pool[$urandom_range(0, KEY_POOL - 1)];
            base_now += $urandom_range(0, max_step);
            if (base_now > 64'hFFFF_FFFF) base_now = 64'hFFFF_FFFF;
            at = TIME_W'(base_now);
            if ($urandom_range(0, 19) == 0) begin
                lower = base_now - 3 * max_step - 1;
                if (lower < 0) lower = 0;
                at = $urandom_range(TIME_W'(lower), TIME_W'(base_now));
            end
            send_req(mode, key, at);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [TIME_W-1:0] life;
        board = new();
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // reset lifetime of 1: retirement at equal time, renew hit and miss
        send_req(MODE_COUNT, '0, 32'd0);
        send_req(MODE_RENEW, 32'd5, 32'd0);
        send_req(MODE_GEN, '0, 32'd0);
        send_req(MODE_COUNT, '0, 32'd0);
        send_req(MODE_COUNT, '0, 32'd1);
        send_req(MODE_GEN, '1, 32'd1);
        send_req(MODE_RENEW, '1, 32'd1);
        send_req(MODE_SPARE, TKEY_W'($urandom), 32'd1);
        send_req(MODE_RENEW, '1, 32'd2);

        // fill the table, overflow it, refresh one key and let the rest lapse
        write_lifetime(32'd1000);
        for (int i = 0; i < ENTRIES; i++)
            send_req(MODE_GEN, {8{4'(i)}}, 32'd100);
        send_req(MODE_GEN, 32'h1234_5678, 32'd100);
        send_req(MODE_GEN, {8{4'd3}}, 32'd1099);
        send_req(MODE_COUNT, '0, 32'd1100);
        // time stepping back
        send_req(MODE_COUNT, '0, 32'd50);
        base_now = 1100;

        life = $urandom_range(8, 64);
        run_phase(life, 4, 350, 1'b0);
        run_phase(32'd1, 1, 300, 1'b0);
        life = $urandom_range(200, 2000);
        run_phase(life, life / 10, 350, 1'b0);
        run_phase(32'h0001_0000, 32'h0001_0000 / 6, 350, 1'b0);

        // longest lifetime near the top of time: expiries past 32 bits
        base_now = 64'hFFFF_0000;
        run_phase('1, 255, 350, 1'b1);
        send_req(MODE_GEN, TKEY_W'($urandom), '1);
        send_req(MODE_COUNT, '0, '1);

        drain_replies();
        repeat (30) @(posedge clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
